### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define TRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define TRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### src/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the run-length image decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

  // Header layout
  localparam int unsigned HDR_SIG_LEN  = 12;  // bytes checked against signature
  localparam int unsigned HDR_TYPE_IDX = 2;   // position of the image type byte
  localparam int unsigned HDR_W_LO     = 12;
  localparam int unsigned HDR_W_HI     = 13;
  localparam int unsigned HDR_H_LO     = 14;
  localparam int unsigned HDR_H_HI     = 15;
  localparam int unsigned HDR_DEPTH    = 16;

  localparam logic [7:0] IMG_TYPE_RLE = 8'h0A;
  localparam logic [7:0] DEPTH_24     = 8'd24;
  localparam logic [7:0] DEPTH_32     = 8'd32;
  localparam logic [7:0] PKT_RUN_BIT  = 8'd128;  // at or above: repeat packet
  localparam logic [7:0] PKT_RUN_BIAS = 8'd127;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SIG   = 2'd1;
  localparam logic [1:0] ST_BAD_DEPTH = 2'd2;
  localparam logic [1:0] ST_CLIPPED   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] repeat_count;
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       image_done;
    logic [1:0] status;
  } result_t;

endpackage

### src/trd_in_stage.sv
// ----------------------------------------------------------------------------
// trd_in_stage
// Input register: captures one byte beat and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module trd_in_stage import trd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     s_valid,
  output logic     s_ready,
  input  in_item_t s_item,
  output logic     q_valid,
  input  logic     q_take,
  output in_item_t q_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign s_ready   = !valid_r || q_take;
  assign valid_nxt = s_valid ? 1'b1 : (valid_r && !q_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload: load on every accepted beat.
  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item_r <= s_item;
    end
  end

  assign q_valid = valid_r;
  assign q_item  = item_r;

endmodule

### src/trd_parser.sv
// ----------------------------------------------------------------------------
// trd_parser
// Header check, packet parse and pixel gather; one byte per step.
// ----------------------------------------------------------------------------
module trd_parser import trd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,       // consume the presented byte this cycle
  input  in_item_t item,
  output logic     emit,       // presented byte yields a result
  output result_t  result
);

  typedef enum logic [1:0] {PH_HEADER, PH_PACKET, PH_PIXEL, PH_IDLE} phase_t;

  phase_t      phase_r,    phase_nxt;
  logic [4:0]  hdr_idx_r,  hdr_idx_nxt;
  logic [15:0] width_r,    width_nxt;
  logic [15:0] height_r,   height_nxt;
  logic        four_r,     four_nxt;
  logic        rep_r,      rep_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic [1:0]  bip_r,      bip_nxt;
  logic [31:0] gather_r,   gather_nxt;
  logic [31:0] pix_left_r, pix_left_nxt;

  // Start-of-file view of the parse state
  phase_t      ph_e;
  logic [4:0]  idx_e;
  logic        rep_e;
  logic [7:0]  pkt_e;
  logic [1:0]  bip_e;
  logic [31:0] gat_e;
  logic [31:0] pix_e;

  logic [7:0]  b;
  logic [31:0] area;
  logic [31:0] gat_new;
  logic [1:0]  bip_inc;
  logic        pix_done;
  logic [7:0]  count;
  logic [7:0]  expect_b;

  assign b    = item.data_byte;
  assign area = 32'(width_r) * 32'(height_r);

  always_comb begin
    if (item.frame_start) begin
      ph_e  = PH_HEADER;
      idx_e = '0;
      rep_e = 1'b0;
      pkt_e = '0;
      bip_e = '0;
      gat_e = '0;
      pix_e = '0;
    end else begin
      ph_e  = phase_r;
      idx_e = hdr_idx_r;
      rep_e = rep_r;
      pkt_e = pkt_left_r;
      bip_e = bip_r;
      gat_e = gather_r;
      pix_e = pix_left_r;
    end
  end

  assign gat_new  = gat_e | (32'(b) << {bip_e, 3'b000});
  assign bip_inc  = bip_e + 2'd1;
  assign pix_done = (bip_inc == 2'd0) || (!four_r && (bip_inc == 2'd3));
  assign expect_b = (idx_e == 5'(HDR_TYPE_IDX)) ? IMG_TYPE_RLE : 8'd0;

  always_comb begin
    phase_nxt    = ph_e;
    hdr_idx_nxt  = idx_e;
    width_nxt    = width_r;
    height_nxt   = height_r;
    four_nxt     = four_r;
    rep_nxt      = rep_e;
    pkt_left_nxt = pkt_e;
    bip_nxt      = bip_e;
    gather_nxt   = gat_e;
    pix_left_nxt = pix_e;
    count        = '0;
    emit         = 1'b0;
    result       = '0;

    unique case (ph_e)
      PH_HEADER: begin
        hdr_idx_nxt = idx_e + 5'd1;
        priority if (idx_e < 5'(HDR_SIG_LEN)) begin
          if (b != expect_b) begin
            emit          = 1'b1;
            result.status = ST_BAD_SIG;
            phase_nxt     = PH_IDLE;
            hdr_idx_nxt   = idx_e;
          end
        end else if (idx_e == 5'(HDR_W_LO)) begin
          width_nxt[7:0] = b;
        end else if (idx_e == 5'(HDR_W_HI)) begin
          width_nxt[15:8] = b;
        end else if (idx_e == 5'(HDR_H_LO)) begin
          height_nxt[7:0] = b;
        end else if (idx_e == 5'(HDR_H_HI)) begin
          height_nxt[15:8] = b;
        end else if (idx_e == 5'(HDR_DEPTH)) begin
          priority if (b == DEPTH_24) begin
            four_nxt = 1'b0;
          end else if (b == DEPTH_32) begin
            four_nxt = 1'b1;
          end else begin
            emit          = 1'b1;
            result.status = ST_BAD_DEPTH;
            phase_nxt     = PH_IDLE;
            hdr_idx_nxt   = idx_e;
          end
        end else begin
          // Last header byte: load pixel budget; empty image goes idle.
          pix_left_nxt = area;
          phase_nxt    = (area != 32'd0) ? PH_PACKET : PH_IDLE;
        end
      end

      PH_PACKET: begin
        if (b < PKT_RUN_BIT) begin
          rep_nxt      = 1'b0;
          pkt_left_nxt = b + 8'd1;
        end else begin
          rep_nxt      = 1'b1;
          pkt_left_nxt = b - PKT_RUN_BIAS;
        end
        bip_nxt    = '0;
        gather_nxt = '0;
        phase_nxt  = PH_PIXEL;
      end

      PH_PIXEL: begin
        bip_nxt    = bip_inc;
        gather_nxt = gat_new;
        if (pix_done) begin
          bip_nxt       = '0;
          gather_nxt    = '0;
          emit          = 1'b1;
          result.blue   = gat_new[7:0];
          result.green  = gat_new[15:8];
          result.red    = gat_new[23:16];
          result.alpha  = four_r ? gat_new[31:24] : 8'd0;
          result.status = ST_OK;
          if (rep_e) begin
            if (32'(pkt_e) > pix_e) begin
              count         = pix_e[7:0];
              result.status = ST_CLIPPED;
            end else begin
              count = pkt_e;
            end
            pkt_left_nxt = '0;
          end else begin
            count        = (pix_e != 32'd0) ? 8'd1 : 8'd0;
            pkt_left_nxt = (pkt_e != 8'd0) ? pkt_e - 8'd1 : 8'd0;
          end
          pix_left_nxt = pix_e - 32'(count);
          // Raw packet still holding pixels at image end
          if (pix_left_nxt == 32'd0 && pkt_left_nxt != 8'd0) begin
            result.status = ST_CLIPPED;
          end
          result.repeat_count = count;
          if (pix_left_nxt == 32'd0) begin
            result.image_done = 1'b1;
            phase_nxt         = PH_IDLE;
          end else if (pkt_left_nxt == 8'd0) begin
            phase_nxt = PH_PACKET;
          end
        end
      end

      PH_IDLE: begin
        // drop bytes until the next start of file
      end

      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_idx_r  <= '0;
      width_r    <= '0;
      height_r   <= '0;
      four_r     <= 1'b0;
      rep_r      <= 1'b0;
      pkt_left_r <= '0;
      bip_r      <= '0;
      gather_r   <= '0;
      pix_left_r <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      hdr_idx_r  <= hdr_idx_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      four_r     <= four_nxt;
      rep_r      <= rep_nxt;
      pkt_left_r <= pkt_left_nxt;
      bip_r      <= bip_nxt;
      gather_r   <= gather_nxt;
      pix_left_r <= pix_left_nxt;
    end
  end

endmodule

### src/trd_out_stage.sv
// ----------------------------------------------------------------------------
// trd_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module trd_out_stage import trd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t d_result,
  output logic    free,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_result
);

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  assign free      = !valid_r || m_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !m_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= d_result;
    end
  end

  assign m_valid  = valid_r;
  assign m_result = result_r;

endmodule

### src/tga_rle_image_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_image_decoder
// Streaming decoder for run-length compressed 24/32-bit image files (type 10).
// ----------------------------------------------------------------------------
// Feed the file one byte per beat, with in_tuser[0] high on the first header
// byte of each file. The block checks the 18-byte header (signature, depth 24
// or 32), reads width and height, then walks the packets and returns one
// result beat per decoded pixel or run: color bytes plus a repeat count (1 for
// raw pixels, the run length for repeat packets). Header errors give a single
// beat with status 1 or 2; runs past the image end are clipped and flagged
// with status 3; tlast marks the beat holding the final pixel. After an error,
// an empty image or the image end, bytes are dropped until the next start of
// file. Throughput is one byte per cycle sustained while the result stream is
// not stalled: each byte passes an input register and one step of the parser
// (counters, gather register and a 16x16 multiply for the pixel budget), and a
// byte that yields a result lands in the result register. A stalled result only
// blocks input when the byte under decode would produce another result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tga_rle_image_decoder import trd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] blue, [15:8] green, [23:16] red,
                                  // [31:24] alpha, [39:32] repeat_count
  output logic        out_tlast,  // image_done
  output logic [1:0]  out_tuser   // [1:0] status
);

  in_item_t in_item;
  in_item_t q_item;
  logic     q_valid;
  logic     q_take;
  logic     emit;
  logic     out_free;
  result_t  pix_result;
  result_t  out_result;

  assign in_item.data_byte   = in_tdata;
  assign in_item.frame_start = in_tuser[0];

  // Advance the held byte unless it produces a result and the output is full.
  assign q_take = q_valid && (!emit || out_free);

  trd_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_item  (in_item),
    .q_valid (q_valid),
    .q_take  (q_take),
    .q_item  (q_item)
  );

  trd_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (q_take),
    .item   (q_item),
    .emit   (emit),
    .result (pix_result)
  );

  trd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (q_take && emit),
    .d_result (pix_result),
    .free     (out_free),
    .m_valid  (out_tvalid),
    .m_ready  (out_tready),
    .m_result (out_result)
  );

  assign out_tdata = {out_result.repeat_count, out_result.alpha, out_result.red,
                      out_result.green, out_result.blue};
  assign out_tlast = out_result.image_done;
  assign out_tuser = out_result.status;

  // Header errors carry no pixel count.
  `TRD_ASSERT_IMP(a_err_no_count,
    out_tvalid && (out_tuser == ST_BAD_SIG || out_tuser == ST_BAD_DEPTH),
    out_tdata[39:32] == 8'd0)

  // Decoded pixels always cover at least one and at most one packet of pixels.
  `TRD_ASSERT_IMP(a_pix_count_range,
    out_tvalid && (out_tuser == ST_OK || out_tuser == ST_CLIPPED),
    out_tdata[39:32] != 8'd0 && out_tdata[39:32] <= PKT_RUN_BIT)

  // Image end is never flagged on a header error.
  `TRD_ASSERT_IMP(a_done_not_err,
    out_tvalid && out_tlast,
    out_tuser == ST_OK || out_tuser == ST_CLIPPED)

  // A result is only loaded when the output slot is free.
  `TRD_ASSERT_IMP(a_no_overwrite,
    q_take && emit,
    out_free)

endmodule
